// ===== sv/header_tail_frame_echo_assert.svh =====
// Assertion macros for the frame echo RTL, used by htfe_ctrl.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef HEADER_TAIL_FRAME_ECHO_ASSERT_SVH
`define HEADER_TAIL_FRAME_ECHO_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define HTFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define HTFE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/htfe_pkg.sv =====
// Types and constants for the header/tail frame echo block.
// No dependencies; imported by every module of the block.
package htfe_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned MaxLenW = 5;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [ByteW-1:0] HeaderFirstRst = 8'h3A;
  localparam logic [ByteW-1:0] HeaderSecondRst = 8'h3B;
  localparam logic [ByteW-1:0] TailFirstRst = 8'h7E;
  localparam logic [ByteW-1:0] TailSecondRst = 8'h7F;
  localparam logic [MaxLenW-1:0] MaxFrameBytesRst = 5'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER_FIRST = 3'd0,
    CFG_HEADER_SECOND = 3'd1,
    CFG_TAIL_FIRST = 3'd2,
    CFG_TAIL_SECOND = 3'd3,
    CFG_MAX_FRAME_BYTES = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    ST_COLLECT,
    ST_REPLAY
  } state_e;

  // Command from the controller to the row of byte cells.
  typedef struct packed {
    logic wr;     // load the incoming byte into the addressed cell
    logic shift;  // move every cell one place toward cell 0
  } cell_cmd_t;

endpackage

// ===== sv/htfe_cell.sv =====
// One byte cell of the frame store row.
// Depends on htfe_pkg; instantiated in a chain by header_tail_frame_echo.
module htfe_cell import htfe_pkg::*; #(
  parameter int unsigned AddrW = 4,
  parameter int unsigned Index = 0
) (
  input  logic             clk_i,
  input  cell_cmd_t        cmd_i,
  input  logic [AddrW-1:0] pos_i,
  input  logic [ByteW-1:0] wr_byte_i,
  input  logic [ByteW-1:0] next_byte_i,
  output logic [ByteW-1:0] byte_o
);

  logic [ByteW-1:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && (pos_i == AddrW'(Index))) begin
      byte_q <= wr_byte_i;
    end else if (cmd_i.shift) begin
      byte_q <= next_byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

// ===== sv/htfe_ctrl.sv =====
// Frame parser, configuration registers and replay sequencer.
// Depends on htfe_pkg and header_tail_frame_echo_assert.svh.
`include "header_tail_frame_echo_assert.svh"

module htfe_ctrl import htfe_pkg::*; #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4,
  parameter int unsigned CntW = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ByteW-1:0]   in_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_last_o,
  output cell_cmd_t          cmd_o,
  output logic [AddrW-1:0]   pos_o
);

  localparam int unsigned MaxW = (CntW > MaxLenW) ? CntW : MaxLenW;

  logic [ByteW-1:0]   hdr_first_q, hdr_second_q, tail_first_q, tail_second_q;
  logic [MaxLenW-1:0] max_len_q;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic            hf_q, hf_d, hs_q, hs_d, tf_q, tf_d;

  logic [AddrW-1:0] pos;
  logic [CntW-1:0]  cnt_inc;
  logic [MaxW-1:0]  limit;
  logic             done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q   <= HeaderFirstRst;
      hdr_second_q  <= HeaderSecondRst;
      tail_first_q  <= TailFirstRst;
      tail_second_q <= TailSecondRst;
      max_len_q     <= MaxFrameBytesRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HEADER_FIRST:    hdr_first_q   <= cfg_data_i;
        CFG_HEADER_SECOND:   hdr_second_q  <= cfg_data_i;
        CFG_TAIL_FIRST:      tail_first_q  <= cfg_data_i;
        CFG_TAIL_SECOND:     tail_second_q <= cfg_data_i;
        CFG_MAX_FRAME_BYTES: max_len_q     <= cfg_data_i[MaxLenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      cnt_q   <= '0;
      rem_q   <= '0;
      hf_q    <= 1'b0;
      hs_q    <= 1'b0;
      tf_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      hf_q    <= hf_d;
      hs_q    <= hs_d;
      tf_q    <= tf_d;
    end
  end

  assign pos = (cnt_q >= CntW'(Depth)) ? AddrW'(Depth - 1) : cnt_q[AddrW-1:0];
  assign cnt_inc = CntW'(pos) + CntW'(1);
  assign limit = (MaxW'(max_len_q) > MaxW'(Depth)) ? MaxW'(Depth) : MaxW'(max_len_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    hf_d        = hf_q;
    hs_d        = hs_q;
    tf_d        = tf_q;
    cmd_o       = '0;
    done        = 1'b0;
    in_ready_o  = (state_q == ST_COLLECT);
    out_valid_o = (state_q == ST_REPLAY);
    out_last_o  = (rem_q == CntW'(1));
    unique case (state_q)
      ST_COLLECT: begin
        if (in_valid_i) begin
          cmd_o.wr = 1'b1;
          if (hs_q) begin
            if (tf_q) begin
              if (in_byte_i == tail_second_q) begin
                done    = 1'b1;
                rem_d   = cnt_inc;
                state_d = ST_REPLAY;
              end else begin
                tf_d  = 1'b0;
                cnt_d = cnt_inc;
              end
            end else begin
              if (in_byte_i == tail_first_q) begin
                tf_d = 1'b1;
              end
              cnt_d = cnt_inc;
            end
          end else if (hf_q) begin
            if (in_byte_i == hdr_second_q) begin
              hs_d  = 1'b1;
              cnt_d = cnt_inc;
            end else begin
              hf_d  = 1'b0;
              cnt_d = '0;
            end
          end else begin
            if (in_byte_i == hdr_first_q) begin
              hf_d  = 1'b1;
              cnt_d = cnt_inc;
            end else begin
              cnt_d = '0;
            end
          end
          if (done || (MaxW'(cnt_d) >= limit)) begin
            cnt_d = '0;
            hf_d  = 1'b0;
            hs_d  = 1'b0;
            tf_d  = 1'b0;
          end
        end
      end
      ST_REPLAY: begin
        if (out_ready_i) begin
          cmd_o.shift = 1'b1;
          rem_d       = rem_q - CntW'(1);
          if (rem_q == CntW'(1)) begin
            state_d = ST_COLLECT;
          end
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  assign pos_o = pos;

  `HTFE_ASSERT(a_no_overlap, !(in_ready_o && out_valid_o),
    "input accepted during replay")
  `HTFE_ASSERT(a_rem_nonzero, (state_q == ST_REPLAY) |-> (rem_q != '0),
    "replay with empty count")
  `HTFE_ASSERT(a_last_exit, (out_valid_o && out_ready_i && out_last_o) |=> (state_q == ST_COLLECT),
    "replay did not end after last beat")
  `HTFE_ASSERT(a_cnt_bound, cnt_q < CntW'(Depth), "byte count beyond store")
  `HTFE_ASSERT(a_hdr_order, hs_q |-> hf_q, "header seen without first header byte")

endmodule

// ===== sv/header_tail_frame_echo.sv =====
// Top level of the header/tail delimited frame echo.
// Depends on htfe_pkg, htfe_ctrl and htfe_cell.
//
//  Channel  Dir  Signals                          Contents
//  s_axis   in   tvalid tready tdata[7:0]         rx_byte
//  m_axis   out  tvalid tready tdata[7:0] tlast   tx_byte, frame_last
//  cfg      in   cfg_we_i cfg_idx_i cfg_data_i    register writes, no read-back
//
//  One input beat per cycle while collecting; the byte lands in its cell directly.
//  The beat that completes the tail starts replay on the next cycle: an N-byte frame
//  leaves in N output beats, shifted out of the cell row through cell 0.
//  Input is held off (tready low) for the whole replay, so input never overlaps output.
//  Reset clears parser flags and byte count, presets the registers; cells hold data only.
//  A stalled output beat holds cell 0 and the count.
module header_tail_frame_echo import htfe_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [ByteW-1:0]   s_axis_tdata,   // [7:0] rx_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [ByteW-1:0]   m_axis_tdata,   // [7:0] tx_byte
  output logic               m_axis_tlast
);

  localparam int unsigned AddrW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(STORE_DEPTH + 1);

  cell_cmd_t        cmd;
  logic [AddrW-1:0] pos;
  logic [ByteW-1:0] cell_byte [STORE_DEPTH+1];

  htfe_ctrl #(
    .Depth (STORE_DEPTH),
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .cmd_o       (cmd),
    .pos_o       (pos)
  );

  assign cell_byte[STORE_DEPTH] = '0;

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    htfe_cell #(
      .AddrW (AddrW),
      .Index (i)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .pos_i       (pos),
      .wr_byte_i   (s_axis_tdata),
      .next_byte_i (cell_byte[i+1]),
      .byte_o      (cell_byte[i])
    );
  end

  assign m_axis_tdata = cell_byte[0];

endmodule

// ===== sim/tb_header_tail_frame_echo.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for header_tail_frame_echo: frames go in byte by byte,
// and each echoed frame is checked against a cycle-free framing predictor.
// Depends on htfe_pkg and the header_tail_frame_echo RTL.
module tb_header_tail_frame_echo;
  import htfe_pkg::*;

  localparam int unsigned StoreDepth = 16;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd5;
  localparam int unsigned RandomBytesPerPhase = 55;
  localparam int unsigned SettleCycles = 4;

  typedef struct packed {
    logic [ByteW-1:0] tx_byte;
    logic             frame_last;
  } echo_beat_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [ByteW-1:0]   cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [ByteW-1:0]   s_axis_tdata = '0;   // [7:0] rx_byte
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [ByteW-1:0]   m_axis_tdata;        // [7:0] tx_byte
  logic               m_axis_tlast;

  // framing settings as the block should hold them
  logic [ByteW-1:0]   cfg_header_first = HeaderFirstRst;
  logic [ByteW-1:0]   cfg_header_second = HeaderSecondRst;
  logic [ByteW-1:0]   cfg_tail_first = TailFirstRst;
  logic [ByteW-1:0]   cfg_tail_second = TailSecondRst;
  logic [MaxLenW-1:0] cfg_max_len = MaxFrameBytesRst;

  // frame parser state
  logic [ByteW-1:0]   frame_copy [StoreDepth];
  int unsigned        frame_len = 0;
  bit                 header_armed = 1'b0;
  bit                 in_payload = 1'b0;
  bit                 tail_pending = 1'b0;

  echo_beat_t         expected_echo [$];

  int unsigned        tx_gap_pct = 16;
  int unsigned        rx_stall_pct = 59;
  int unsigned        fails = 0;
  int unsigned        bytes_sent = 0;
  int unsigned        beats_checked = 0;
  int unsigned        frames_echoed = 0;
  int unsigned        settings_applied = 0;

  header_tail_frame_echo #(
    .STORE_DEPTH(StoreDepth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_header_tail_frame_echo NOT OK");
    $finish;
  end

  function automatic void drop_frame();
    frame_len = 0;
    header_armed = 1'b0;
    in_payload = 1'b0;
    tail_pending = 1'b0;
  endfunction

  function automatic int unsigned frame_limit();
    return (cfg_max_len > StoreDepth) ? StoreDepth : cfg_max_len;
  endfunction

  // payload bytes that still fit a frame under the current limit
  function automatic int unsigned payload_room();
    return (frame_limit() > 4) ? frame_limit() - 4 : 0;
  endfunction

  function automatic void predict_echo(input logic [ByteW-1:0] rx);
    int unsigned pos;
    pos = (frame_len >= StoreDepth) ? StoreDepth - 1 : frame_len;
    frame_copy[pos] = rx;
    if (in_payload) begin
      if (tail_pending && rx == cfg_tail_second) begin
        for (int unsigned i = 0; i <= pos; i++) begin
          expected_echo.push_back('{tx_byte: frame_copy[i], frame_last: (i == pos)});
        end
        frames_echoed++;
        drop_frame();
        return;
      end
      tail_pending = !tail_pending && (rx == cfg_tail_first);
      frame_len = pos + 1;
    end else if (header_armed) begin
      if (rx == cfg_header_second) begin
        in_payload = 1'b1;
        frame_len = pos + 1;
      end else begin
        header_armed = 1'b0;
        frame_len = 0;
      end
    end else if (rx == cfg_header_first) begin
      header_armed = 1'b1;
      frame_len = pos + 1;
    end else begin
      frame_len = 0;
    end
    if (frame_len >= frame_limit()) drop_frame();
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin : monitor
    echo_beat_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_echo(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        beats_checked++;
        if (expected_echo.size() == 0) begin
          $error("unexpected beat: tx_byte 0x%02h, frame_last %0b", m_axis_tdata, m_axis_tlast);
          fails++;
        end else begin
          want = expected_echo.pop_front();
          if (m_axis_tdata !== want.tx_byte) begin
            $error("tx_byte mismatch: expected 0x%02h, got 0x%02h", want.tx_byte, m_axis_tdata);
            fails++;
          end
          if (m_axis_tlast !== want.frame_last) begin
            $error("frame_last mismatch: expected %0b, got %0b", want.frame_last, m_axis_tlast);
            fails++;
          end
        end
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] value);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_gap_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // hold input, then wait for every echo and let the block settle
  task automatic drain_echo();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_echo.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_HEADER_FIRST:    cfg_header_first = value;
      CFG_HEADER_SECOND:   cfg_header_second = value;
      CFG_TAIL_FIRST:      cfg_tail_first = value;
      CFG_TAIL_SECOND:     cfg_tail_second = value;
      CFG_MAX_FRAME_BYTES: cfg_max_len = value[MaxLenW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_framing(input logic [ByteW-1:0] h1, input logic [ByteW-1:0] h2,
                             input logic [ByteW-1:0] t1, input logic [ByteW-1:0] t2,
                             input logic [ByteW-1:0] max_len);
    write_reg(CFG_HEADER_FIRST, h1);
    write_reg(CFG_HEADER_SECOND, h2);
    write_reg(CFG_TAIL_FIRST, t1);
    write_reg(CFG_TAIL_SECOND, t2);
    write_reg(CFG_MAX_FRAME_BYTES, max_len);
    settings_applied++;
  endtask

  task automatic send_frame(input int unsigned payload_len, input bit break_tail);
    logic [ByteW-1:0] filler;
    send_byte(cfg_header_first);
    send_byte(cfg_header_second);
    for (int unsigned i = 0; i < payload_len; i++) begin
      filler = ByteW'($urandom_range(255));
      if (break_tail && i == 0) begin
        filler = cfg_tail_first;
      end else if (break_tail && i == 1) begin
        while (filler == cfg_tail_second) filler = ByteW'($urandom_range(255));
      end
      send_byte(filler);
    end
    send_byte(cfg_tail_first);
    send_byte(cfg_tail_second);
  endtask

  task automatic test_default_frame();
    send_byte(HeaderFirstRst);
    send_byte(HeaderSecondRst);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(TailFirstRst);
    send_byte(TailSecondRst);
    drain_echo();
  endtask

  // a repeated first header byte must not restart the header
  task automatic test_wrong_second_header();
    send_byte(HeaderFirstRst);
    send_byte(HeaderFirstRst);
    send_byte(HeaderSecondRst);
    send_byte(TailFirstRst);
    send_byte(TailSecondRst);
    drain_echo();
  endtask

  task automatic test_broken_tail();
    send_byte(HeaderFirstRst);
    send_byte(HeaderSecondRst);
    send_byte(TailFirstRst);
    send_byte(TailFirstRst);
    send_byte(TailSecondRst);
    send_byte(TailFirstRst);
    send_byte(TailSecondRst);
    drain_echo();
  endtask

  task automatic test_limit_lowered();
    write_reg(CFG_MAX_FRAME_BYTES, 8'd16);
    send_byte(HeaderFirstRst);
    send_byte(HeaderSecondRst);
    send_byte(8'h01);
    send_byte(8'h02);
    drain_echo();
    write_reg(CFG_MAX_FRAME_BYTES, 8'd4);
    write_reg(CfgIdxSpare, 8'hA5);
    settings_applied++;
    send_byte(TailFirstRst);
    send_byte(TailSecondRst);
    send_byte(HeaderFirstRst);
    send_byte(HeaderSecondRst);
    send_byte(TailFirstRst);
    send_byte(TailSecondRst);
    drain_echo();
  endtask

  task automatic test_random_traffic();
    int unsigned phase_start;
    int unsigned pick;
    int unsigned room;
    bit paused;
    logic [ByteW-1:0] bad;
    for (int unsigned phase_idx = 0; phase_idx < 3; phase_idx++) begin
      tx_gap_pct = (phase_idx == 0) ? 16 : (phase_idx == 1) ? 59 : 0;
      rx_stall_pct = (phase_idx == 0) ? 59 : (phase_idx == 1) ? 16 : 0;
      drain_echo();
      if (phase_idx == 0) begin
        set_framing(8'h00, 8'hFF, 8'hFF, 8'h00, 8'd31);
        send_frame(payload_room(), 1'b0);
      end else begin
        set_framing(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
                    ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
                    (phase_idx == 1) ? 8'd4 : 8'd16);
      end
      phase_start = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - phase_start < RandomBytesPerPhase) begin
        if (!paused && bytes_sent - phase_start >= RandomBytesPerPhase / 2) begin
          paused = 1'b1;
          drain_echo();
          set_framing(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
                      ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
                      ByteW'($urandom_range(16, 4)));
        end
        room = payload_room();
        pick = $urandom_range(99);
        if (pick < 65) begin
          send_frame($urandom_range(room, 0), 1'b0);
        end else if (pick < 73) begin
          bad = ByteW'($urandom_range(255));
          while (bad == cfg_header_second) bad = ByteW'($urandom_range(255));
          send_byte(cfg_header_first);
          send_byte(bad);
          send_byte(cfg_tail_first);
          send_byte(cfg_tail_second);
        end else if (pick < 81) begin
          send_frame(room + $urandom_range(3, 1), 1'b0);
        end else if (pick < 90) begin
          send_frame($urandom_range((room > 2) ? room : 2, 2), 1'b1);
        end else begin
          repeat ($urandom_range(3, 1)) send_byte(ByteW'($urandom_range(255)));
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_frame();
    test_wrong_second_header();
    test_broken_tail();
    test_limit_lowered();
    test_random_traffic();
    drain_echo();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d input beats; checked %0d echoed beats in %0d frames.",
             bytes_sent, beats_checked, frames_echoed);
    $display("Ran %0d framing settings under three stall patterns.", settings_applied);
    if (fails == 0) begin
      $display("tb_header_tail_frame_echo OK");
    end else begin
      $display("tb_header_tail_frame_echo NOT OK");
    end
    $finish;
  end

endmodule
